@@ rtl/core/take_back_half_controller_macros.svh @@
// assertion macros for the take-back-half controller
// no dependencies; included by the files that carry assertions
`ifndef TAKE_BACK_HALF_CONTROLLER_MACROS_SVH
`define TAKE_BACK_HALF_CONTROLLER_MACROS_SVH

// same-cycle implication, disabled during reset
`define TBH_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("tbh assertion failed");

// next-cycle implication, disabled during reset
`define TBH_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("tbh assertion failed");

`endif

@@ rtl/core/tbh_pkg.sv @@
// shared types and constants of the take-back-half controller
// no dependencies; imported by the interfaces, controller, datapath and top
package tbh_pkg;

	localparam int Q_W    = 32;                 // signed q16.16 word
	localparam int DT_W   = 24;                 // unsigned q8.16 time step
	localparam int FRAC_W = 16;
	localparam int T1_W   = 39;                 // |error| * dt in unsigned q23.16
	localparam int PH_W   = T1_W - FRAC_W + Q_W; // high partial product
	localparam int M_W    = PH_W + 1;           // sum of partial products
	localparam int TERM_W = M_W + 1;            // signed integration term
	localparam int ND_W   = TERM_W + 1;         // drive minus term

	localparam logic [Q_W-1:0] DRIVE_MAX = {1'b0, {(Q_W-1){1'b1}}};
	localparam logic [Q_W-1:0] DRIVE_MIN = {1'b1, {(Q_W-1){1'b0}}};

	typedef enum logic {
		OP_UPDATE = 1'b0,
		OP_CLEAR  = 1'b1
	} op_t;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_MUL1  = 6'b000010,
		ST_MUL2  = 6'b000100,
		ST_MUL3  = 6'b001000,
		ST_INTEG = 6'b010000,
		ST_FIN   = 6'b100000
	} state_t;

	typedef struct packed {
		logic load;     // capture the input item
		logic mul_err;  // |error| * time_step
		logic mul_hi;   // high part times |gain|
		logic mul_lo;   // low part times |gain|
		logic integ;    // integrate and saturate drive
		logic finish;   // crossing logic, history update, result write
	} cmd_t;

	typedef struct packed {
		logic op_clear; // captured item is a clear
		logic res_free; // result register can take a result this cycle
	} sts_t;

endpackage

@@ rtl/core/tbh_if.sv @@
// channel interfaces of the take-back-half controller: item, result, config
// depends on tbh_pkg
interface tbh_item_if import tbh_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic                   op;
	logic signed [Q_W-1:0]  error;
	logic        [DT_W-1:0] time_step;
	logic signed [Q_W-1:0]  target;
	logic signed [Q_W-1:0]  first_cross_estimate;

	modport source (output valid, op, error, time_step, target, first_cross_estimate,
		input ready);
	modport sink (input valid, op, error, time_step, target, first_cross_estimate,
		output ready);
endinterface

interface tbh_result_if import tbh_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic signed [Q_W-1:0] drive;
	logic                  crossed_flag;
	logic                  took_back;
	logic                  saturated;

	modport source (output valid, drive, crossed_flag, took_back, saturated, input ready);
	modport sink (input valid, drive, crossed_flag, took_back, saturated, output ready);
endinterface

interface tbh_cfg_if import tbh_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic signed [Q_W-1:0] gain;

	modport source (output valid, gain, input ready);
	modport sink (input valid, gain, output ready);
endinterface

@@ rtl/core/tbh_ctrl.sv @@
// sequencing state machine of the take-back-half controller
// depends on tbh_pkg; drives the datapath through cmd_t, reads sts_t
module tbh_ctrl import tbh_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_nxt;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd         = '0;
		state_nxt   = state_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid;
				if (in_valid) begin
					state_nxt = ST_MUL1;
				end
			end
			ST_MUL1: begin
				cmd.mul_err = !sts.op_clear;
				state_nxt   = sts.op_clear ? ST_FIN : ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul_hi = 1'b1;
				state_nxt  = ST_MUL3;
			end
			ST_MUL3: begin
				cmd.mul_lo = 1'b1;
				state_nxt  = ST_INTEG;
			end
			ST_INTEG: begin
				cmd.integ = 1'b1;
				state_nxt = ST_FIN;
			end
			ST_FIN: begin
				// hold here while the previous result is still waiting
				cmd.finish = sts.res_free;
				if (sts.res_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

@@ rtl/core/tbh_dp.sv @@
// datapath of the take-back-half controller: multiplies, integration,
// crossing logic, history registers and result register; depends on tbh_pkg
module tbh_dp import tbh_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	output sts_t                   sts,
	input  logic                   cfg_we,
	input  logic signed [Q_W-1:0]  cfg_gain,
	input  logic                   in_op,
	input  logic signed [Q_W-1:0]  in_error,
	input  logic        [DT_W-1:0] in_time_step,
	input  logic signed [Q_W-1:0]  in_target,
	input  logic signed [Q_W-1:0]  in_estimate,
	input  logic                   res_ready,
	output logic                   res_valid,
	output logic signed [Q_W-1:0]  res_drive,
	output logic                   res_crossed,
	output logic                   res_took,
	output logic                   res_sat
);

	// configuration and history
	logic signed [Q_W-1:0] gain_q;
	logic signed [Q_W-1:0] drive_q;
	logic signed [Q_W-1:0] last_drive_q;
	logic signed [Q_W-1:0] last_err_q;
	logic signed [Q_W-1:0] last_sp_q;
	logic                  crossed_q;

	// captured item
	op_t                   op_q;
	logic signed [Q_W-1:0] err_q;
	logic [DT_W-1:0]       dt_q;
	logic signed [Q_W-1:0] tgt_q;
	logic signed [Q_W-1:0] est_q;

	// intermediate products
	logic [T1_W-1:0] t1_q;
	logic [PH_W-1:0] ph_q;
	logic [Q_W-1:0]  pl_q;
	logic            sat_q;

	// result register
	logic                  res_valid_q;
	logic signed [Q_W-1:0] res_drive_q;
	logic                  res_crossed_q;
	logic                  res_took_q;
	logic                  res_sat_q;

	logic [Q_W-1:0]           mag_err;
	logic [Q_W-1:0]           mag_gain;
	logic [Q_W+DT_W-1:0]      p_err;
	logic [FRAC_W+Q_W-1:0]    p_lo;
	logic [M_W-1:0]           m_sum;
	logic signed [TERM_W-1:0] term;
	logic signed [ND_W-1:0]   nd;
	logic                     nd_ovf;
	logic                     tgt_chg;
	logic                     cross_eff;
	logic                     took;
	logic [Q_W:0]             avg_sum;
	logic signed [Q_W-1:0]    new_drive;

	assign mag_err  = err_q[Q_W-1] ? (~err_q + 1'b1) : err_q;
	assign mag_gain = gain_q[Q_W-1] ? (~gain_q + 1'b1) : gain_q;

	assign p_err = {{DT_W{1'b0}}, mag_err} * {{Q_W{1'b0}}, dt_q};
	assign p_lo  = {{Q_W{1'b0}}, t1_q[FRAC_W-1:0]} * {{FRAC_W{1'b0}}, mag_gain};

	// integration: drive - sign * (hi + lo)
	assign m_sum  = {1'b0, ph_q} + {{(M_W-Q_W){1'b0}}, pl_q};
	assign term   = (err_q[Q_W-1] ^ gain_q[Q_W-1]) ? -$signed({1'b0, m_sum})
	                                               : $signed({1'b0, m_sum});
	assign nd     = $signed({{(ND_W-Q_W){drive_q[Q_W-1]}}, drive_q})
	              - $signed({term[TERM_W-1], term});
	assign nd_ovf = (nd[ND_W-1:Q_W-1] != {(ND_W-Q_W+1){1'b0}})
	             && (nd[ND_W-1:Q_W-1] != {(ND_W-Q_W+1){1'b1}});

	// crossing: sign of error against sign of stored error
	assign tgt_chg   = (tgt_q != last_sp_q);
	assign cross_eff = crossed_q && !tgt_chg;
	assign took      = ((err_q == '0) != (last_err_q == '0))
	                || (err_q[Q_W-1] != last_err_q[Q_W-1]);
	assign avg_sum   = {drive_q[Q_W-1], drive_q} + {last_drive_q[Q_W-1], last_drive_q};
	assign new_drive = !took ? drive_q : (cross_eff ? $signed(avg_sum[Q_W:1]) : est_q);

	assign sts.op_clear = (op_q == OP_CLEAR);
	assign sts.res_free = !res_valid_q || res_ready;

	assign res_valid   = res_valid_q;
	assign res_drive   = res_drive_q;
	assign res_crossed = res_crossed_q;
	assign res_took    = res_took_q;
	assign res_sat     = res_sat_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op_t'(in_op);
			err_q <= in_error;
			dt_q  <= in_time_step;
			tgt_q <= in_target;
			est_q <= in_estimate;
		end
		if (cmd.mul_err) begin
			t1_q <= p_err[FRAC_W+T1_W-1:FRAC_W];
		end
		if (cmd.mul_hi) begin
			ph_q <= {{Q_W{1'b0}}, t1_q[T1_W-1:FRAC_W]} * {{(T1_W-FRAC_W){1'b0}}, mag_gain};
		end
		if (cmd.mul_lo) begin
			pl_q <= p_lo[FRAC_W+Q_W-1:FRAC_W];
		end
		if (cmd.integ) begin
			sat_q <= nd_ovf;
		end
		if (cmd.finish) begin
			if (op_q == OP_CLEAR) begin
				res_drive_q   <= drive_q;
				res_crossed_q <= 1'b0;
				res_took_q    <= 1'b0;
				res_sat_q     <= 1'b0;
			end else begin
				res_drive_q   <= new_drive;
				res_crossed_q <= took || cross_eff;
				res_took_q    <= took;
				res_sat_q     <= sat_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q       <= '0;
			drive_q      <= '0;
			last_drive_q <= '0;
			last_err_q   <= '0;
			last_sp_q    <= '0;
			crossed_q    <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				gain_q <= cfg_gain;
			end
			if (cmd.integ) begin
				priority if (!nd_ovf) begin
					drive_q <= nd[Q_W-1:0];
				end else if (nd[ND_W-1]) begin
					drive_q <= DRIVE_MIN;
				end else begin
					drive_q <= DRIVE_MAX;
				end
			end
			if (cmd.finish) begin
				if (op_q == OP_CLEAR) begin
					last_drive_q <= '0;
					last_err_q   <= '0;
					last_sp_q    <= '0;
					crossed_q    <= 1'b0;
				end else begin
					drive_q    <= new_drive;
					crossed_q  <= took || cross_eff;
					last_sp_q  <= tgt_q;
					last_err_q <= err_q;
					if (took) begin
						last_drive_q <= new_drive;
					end
				end
			end
			if (cmd.finish) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/core/take_back_half_controller.sv @@
// Take-back-half speed controller, signed q16.16. An update item passes, from
// its transfer to the next item's earliest transfer, through a capture step,
// the three chained multiplies (|error| * time step, then the high and the low
// half of that product times |gain|, one 32-bit multiplier stage each), an
// integrate step that saturates the drive and a finish step that resolves the
// zero crossing and writes the result register. A clear item skips the
// multiplies and the integrate step. The result sits in an output register, so
// a waiting result does not hold up the next item until it reaches its finish
// step. The gain register resets to zero and is written through the config
// channel, which is always ready; write it only while no item is in flight.
// top level; depends on tbh_pkg, tbh_if, tbh_ctrl, tbh_dp and the macro header
`include "take_back_half_controller_macros.svh"

module take_back_half_controller import tbh_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	tbh_item_if.sink      item,
	tbh_result_if.source  result,
	tbh_cfg_if.sink       cfg
);

	cmd_t cmd;   // controller to datapath
	sts_t sts;   // datapath to controller

	// config transfer lands directly in the gain register
	assign cfg.ready = 1'b1;

	// sequencer: capture, three multiply steps, integrate, finish
	tbh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (item.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// arithmetic, history state and the result register
	tbh_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg.valid && cfg.ready),
		.cfg_gain     (cfg.gain),
		.in_op        (item.op),
		.in_error     (item.error),
		.in_time_step (item.time_step),
		.in_target    (item.target),
		.in_estimate  (item.first_cross_estimate),
		.res_ready    (result.ready),
		.res_valid    (result.valid),
		.res_drive    (result.drive),
		.res_crossed  (result.crossed_flag),
		.res_took     (result.took_back),
		.res_sat      (result.saturated)
	);

	// one item in flight: no transfer right after a transfer
	`TBH_ASSERT_NXT(a_one_in_flight, clk, arst_n, item.valid && item.ready, !item.ready)
	// a take-back always leaves the crossed flag set
	`TBH_ASSERT_IMP(a_took_sets_crossed, clk, arst_n, result.valid && result.took_back,
		result.crossed_flag)
	// a clamped drive with no take-back sits at a rail
	`TBH_ASSERT_IMP(a_sat_at_rail, clk, arst_n,
		result.valid && result.saturated && !result.took_back,
		result.drive == DRIVE_MAX || result.drive == DRIVE_MIN)

endmodule
